// ----- rtl/tcud_pkg.sv -----
// Shared types, constants and the 8-bit extra table of the text code-unit decoder.
package tcud_pkg;

  localparam int CP_W       = 21;
  localparam int UNIT_W     = 16;
  localparam int FIFO_DEPTH = 4;
  localparam int PTR_W      = $clog2(FIFO_DEPTH);
  localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

  localparam logic [UNIT_W-1:0] UNIT_BOM       = 16'hFEFF;
  localparam logic [UNIT_W-1:0] UNIT_HIGH_MIN  = 16'hD800;
  localparam logic [UNIT_W-1:0] UNIT_HIGH_MAX  = 16'hDBFF;
  localparam logic [UNIT_W-1:0] UNIT_LOW_MIN   = 16'hDC00;
  localparam logic [UNIT_W-1:0] UNIT_LOW_MAX   = 16'hDFFF;
  localparam logic [CP_W-1:0]   CP_SUPPL_BASE  = 21'h10000;
  localparam logic [7:0]        EXTRA_MIN      = 8'h80;
  localparam logic [7:0]        EXTRA_MAX      = 8'h9F;

  typedef enum logic [1:0] {
    MODE_PLAIN   = 2'd0,
    MODE_EXTRA   = 2'd1,
    MODE_UTF16LE = 2'd2,
    MODE_UTF16BE = 2'd3
  } text_mode_t;

  // One queue entry holds every result caused by one accepted byte.
  typedef struct packed {
    logic [CP_W-1:0] cp0;
    logic [CP_W-1:0] cp1;
    logic            two;
    logic            eot;
  } entry_t;

  function automatic logic [UNIT_W-1:0] extra_map(input logic [4:0] idx);
    logic [UNIT_W-1:0] cp;
    case (idx)
      5'd0:  cp = 16'h20AC;
      5'd1:  cp = 16'h0081;
      5'd2:  cp = 16'h201A;
      5'd3:  cp = 16'h0192;
      5'd4:  cp = 16'h201E;
      5'd5:  cp = 16'h2026;
      5'd6:  cp = 16'h2020;
      5'd7:  cp = 16'h2021;
      5'd8:  cp = 16'h02C6;
      5'd9:  cp = 16'h2030;
      5'd10: cp = 16'h0160;
      5'd11: cp = 16'h2039;
      5'd12: cp = 16'h0152;
      5'd13: cp = 16'h0164;
      5'd14: cp = 16'h017D;
      5'd15: cp = 16'h0179;
      5'd16: cp = 16'h0090;
      5'd17: cp = 16'h2035;
      5'd18: cp = 16'h2032;
      5'd19: cp = 16'h2036;
      5'd20: cp = 16'h2033;
      5'd21: cp = 16'h2022;
      5'd22: cp = 16'h2013;
      5'd23: cp = 16'h2014;
      5'd24: cp = 16'h02DC;
      5'd25: cp = 16'h2122;
      5'd26: cp = 16'h0161;
      5'd27: cp = 16'h203A;
      5'd28: cp = 16'h0153;
      5'd29: cp = 16'h0165;
      5'd30: cp = 16'h017E;
      default: cp = 16'h0178;
    endcase
    return cp;
  endfunction

endpackage

// ----- rtl/tcud_if.sv -----
// Channel interfaces of the text code-unit decoder: byte input, result output, mode write.
interface tcud_text_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       final_byte;
  modport source (output valid, data_byte, final_byte, input ready);
  modport sink   (input valid, data_byte, final_byte, output ready);
endinterface

interface tcud_result_if;
  logic                    valid;
  logic                    ready;
  logic [tcud_pkg::CP_W-1:0] code_point;
  logic                    end_of_text;
  modport source (output valid, code_point, end_of_text, input ready);
  modport sink   (input valid, code_point, end_of_text, output ready);
endinterface

interface tcud_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] text_mode;
  modport source (output valid, text_mode, input ready);
  modport sink   (input valid, text_mode, output ready);
endinterface

// ----- rtl/tcud_front.sv -----
// Front end: accepts bytes, keeps the unit and surrogate state, and forms queue entries.
module tcud_front (
  input  logic            clk,
  input  logic            rst,
  tcud_text_if.sink       text,
  tcud_cfg_if.sink        cfg,
  input  logic            full,
  output logic            push,
  output tcud_pkg::entry_t entry
);
  import tcud_pkg::*;

  text_mode_t        mode;
  logic [7:0]        held_byte, held_byte_next;
  logic              byte_pending, byte_pending_next;
  logic [UNIT_W-1:0] high_unit, high_unit_next;
  logic              high_pending, high_pending_next;

  logic [7:0]        b;
  logic              last;
  logic [UNIT_W-1:0] unit;
  logic              unit_high, unit_low;
  logic [1:0]        n;
  logic [CP_W-1:0]   cp0, cp1;

  assign b         = text.data_byte;
  assign last      = text.final_byte;
  assign unit      = (mode == MODE_UTF16LE) ? {b, held_byte} : {held_byte, b};
  assign unit_high = (unit >= UNIT_HIGH_MIN) && (unit <= UNIT_HIGH_MAX);
  assign unit_low  = (unit >= UNIT_LOW_MIN) && (unit <= UNIT_LOW_MAX);

  assign text.ready = !full;
  assign cfg.ready  = 1'b1;

  always_comb begin
    held_byte_next    = held_byte;
    byte_pending_next = byte_pending;
    high_unit_next    = high_unit;
    high_pending_next = high_pending;
    n   = 2'd0;
    cp0 = '0;
    cp1 = '0;
    unique case (mode) inside
      MODE_PLAIN: begin
        cp0 = {{(CP_W-8){1'b0}}, b};
        n   = 2'd1;
      end
      MODE_EXTRA: begin
        if ((b >= EXTRA_MIN) && (b <= EXTRA_MAX)) begin
          cp0 = {{(CP_W-UNIT_W){1'b0}}, extra_map(b[4:0])};
        end else begin
          cp0 = {{(CP_W-8){1'b0}}, b};
        end
        n = 2'd1;
      end
      MODE_UTF16LE, MODE_UTF16BE: begin
        if (!byte_pending) begin
          if (last) begin
            // Odd trailing byte: a held surrogate goes out first, then a zero.
            if (high_pending) begin
              cp0 = {{(CP_W-UNIT_W){1'b0}}, high_unit};
              n   = 2'd2;
            end else begin
              n   = 2'd1;
            end
          end else begin
            held_byte_next    = b;
            byte_pending_next = 1'b1;
          end
        end else begin
          held_byte_next    = '0;
          byte_pending_next = 1'b0;
          if (high_pending) begin
            high_unit_next    = '0;
            high_pending_next = 1'b0;
            if (unit_low) begin
              cp0 = CP_SUPPL_BASE + {{(CP_W-20){1'b0}}, high_unit[9:0], unit[9:0]};
              n   = 2'd1;
            end else begin
              cp0 = {{(CP_W-UNIT_W){1'b0}}, high_unit};
              n   = 2'd1;
              if (unit != UNIT_BOM) begin
                if (unit_high && !last) begin
                  high_unit_next    = unit;
                  high_pending_next = 1'b1;
                end else begin
                  cp1 = {{(CP_W-UNIT_W){1'b0}}, unit};
                  n   = 2'd2;
                end
              end
            end
          end else if (unit != UNIT_BOM) begin
            if (unit_high && !last) begin
              high_unit_next    = unit;
              high_pending_next = 1'b1;
            end else begin
              cp0 = {{(CP_W-UNIT_W){1'b0}}, unit};
              n   = 2'd1;
            end
          end
        end
      end
    endcase
    if (last) begin
      // The final byte always yields a flagged result and ends the text.
      if (n == 2'd0) begin
        n = 2'd1;
      end
      held_byte_next    = '0;
      byte_pending_next = 1'b0;
      high_unit_next    = '0;
      high_pending_next = 1'b0;
    end
  end

  assign push      = text.valid && text.ready && (n != 2'd0);
  assign entry.cp0 = cp0;
  assign entry.cp1 = cp1;
  assign entry.two = (n == 2'd2);
  assign entry.eot = last;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode         <= MODE_PLAIN;
      held_byte    <= '0;
      byte_pending <= 1'b0;
      high_unit    <= '0;
      high_pending <= 1'b0;
    end else if (cfg.valid && cfg.ready) begin
      mode         <= text_mode_t'(cfg.text_mode);
      held_byte    <= '0;
      byte_pending <= 1'b0;
      high_unit    <= '0;
      high_pending <= 1'b0;
    end else if (text.valid && text.ready) begin
      held_byte    <= held_byte_next;
      byte_pending <= byte_pending_next;
      high_unit    <= high_unit_next;
      high_pending <= high_pending_next;
    end
  end

endmodule

// ----- rtl/tcud_queue.sv -----
// Short register queue of result entries between the front and back ends.
module tcud_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  tcud_pkg::entry_t push_data,
  output logic             full,
  input  logic             pop,
  output tcud_pkg::entry_t head,
  output logic             empty
);
  import tcud_pkg::*;

  entry_t           slots [FIFO_DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push, do_pop;

  assign full    = (count == CNT_W'(FIFO_DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(FIFO_DEPTH-1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(FIFO_DEPTH-1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ----- rtl/tcud_back.sv -----
// Back end: unpacks each queue entry into one or two result beats.
module tcud_back (
  input  logic             clk,
  input  logic             rst,
  input  tcud_pkg::entry_t head,
  input  logic             empty,
  output logic             pop,
  tcud_result_if.source    result
);
  import tcud_pkg::*;

  logic second;
  logic accept, at_last;

  assign at_last            = second || !head.two;
  assign accept             = result.valid && result.ready;
  assign pop                = accept && at_last;
  assign result.valid       = !empty;
  assign result.code_point  = second ? head.cp1 : head.cp0;
  assign result.end_of_text = head.eot && at_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      second <= 1'b0;
    end else if (accept) begin
      second <= !at_last;
    end
  end

endmodule

// ----- rtl/text_code_unit_decoder.sv -----
// Top level of the text code-unit decoder: front end, entry queue and back end.
// A byte's results are registered in the entry queue and leave from its head.
// Throughput: one byte per cycle when the queue is not full; results leave one per
// ready cycle, so a two-result byte takes two output beats; the queue absorbs it.
// Reset (synchronous, active high) selects plain mode, clears held bytes and
// surrogates, and empties the queue; no clearing pass is needed.
module text_code_unit_decoder (
  input  logic          clk,
  input  logic          rst,
  tcud_text_if.sink     text,
  tcud_result_if.source result,
  tcud_cfg_if.sink      cfg
);
  import tcud_pkg::*;

  // The front end decides, in the cycle a byte beat arrives, every result that
  // byte causes and writes them as one entry. It stalls only when the queue is
  // full, so a slow result sink does not hold back the byte side right away.
  logic   push, full, pop, empty;
  entry_t entry, head;

  tcud_front u_front (
    .clk   (clk),
    .rst   (rst),
    .text  (text),
    .cfg   (cfg),
    .full  (full),
    .push  (push),
    .entry (entry)
  );

  // Four entries of slack between the two halves.
  tcud_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (entry),
    .full      (full),
    .pop       (pop),
    .head      (head),
    .empty     (empty)
  );

  // The back end walks the head entry one result beat at a time and flags the
  // last result of the final byte.
  tcud_back u_back (
    .clk    (clk),
    .rst    (rst),
    .head   (head),
    .empty  (empty),
    .pop    (pop),
    .result (result)
  );

endmodule

// ----- rtl/tcud_checker.sv -----
// Port-level assertions of the text code-unit decoder and their bind.
module tcud_checker (
  input logic                      clk,
  input logic                      rst,
  input logic                      text_valid,
  input logic                      text_ready,
  input logic                      result_valid,
  input logic                      result_ready,
  input logic [tcud_pkg::CP_W-1:0] code_point,
  input logic                      end_of_text
);

  // A stalled result beat keeps its payload.
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(code_point)
      && $stable(end_of_text))
    else $error("result beat changed while stalled");

  // The byte side stalls only when results are waiting in the queue.
  a_stall_has_work: assert property (@(posedge clk) disable iff (rst)
    !text_ready |-> result_valid)
    else $error("byte side stalled with no result pending");

  // Right after reset nothing is pending and bytes are taken.
  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !result_valid && text_ready)
    else $error("state left over after reset");

  // Code points never exceed the Unicode range.
  a_cp_range: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> code_point <= 21'h10FFFF)
    else $error("code point out of range");

endmodule

bind text_code_unit_decoder tcud_checker u_tcud_checker (
  .clk          (clk),
  .rst          (rst),
  .text_valid   (text.valid),
  .text_ready   (text.ready),
  .result_valid (result.valid),
  .result_ready (result.ready),
  .code_point   (result.code_point),
  .end_of_text  (result.end_of_text)
);

// ----- tb/tb_text_code_unit_decoder.sv -----
`timescale 1ns / 1ps
// Self-checking testbench of the text code-unit decoder, with its own code-point predictor.

typedef logic [7:0] byte_q_t [$];

typedef struct {
  logic [20:0] cp;
  logic        eot;
} due_cp_t;

// Predicts the code points of every accepted byte and checks the result beats against them.
class code_point_book;
  tcud_pkg::text_mode_t mode;
  logic [7:0]  half_byte;
  logic        half_full;
  logic [15:0] high_word;
  logic        high_held;
  logic [15:0] extra_cp [32];
  logic [20:0] step_cps [$];
  due_cp_t     due [$];
  int          errors;

  function new();
    extra_cp = '{
      16'h20AC, 16'h0081, 16'h201A, 16'h0192, 16'h201E, 16'h2026, 16'h2020, 16'h2021,
      16'h02C6, 16'h2030, 16'h0160, 16'h2039, 16'h0152, 16'h0164, 16'h017D, 16'h0179,
      16'h0090, 16'h2035, 16'h2032, 16'h2036, 16'h2033, 16'h2022, 16'h2013, 16'h2014,
      16'h02DC, 16'h2122, 16'h0161, 16'h203A, 16'h0153, 16'h0165, 16'h017E, 16'h0178
    };
    mode   = tcud_pkg::MODE_PLAIN;
    errors = 0;
    clear_text();
  endfunction

  function void clear_text();
    half_byte = 8'h00;
    half_full = 1'b0;
    high_word = 16'h0000;
    high_held = 1'b0;
  endfunction

  function void set_mode(tcud_pkg::text_mode_t m);
    mode = m;
    clear_text();
  endfunction

  // A complete unit with no high surrogate waiting.
  function void take_unit(logic [15:0] u, logic last);
    if (u == 16'hFEFF)
      return;
    if (u >= 16'hD800 && u <= 16'hDBFF && !last) begin
      high_word = u;
      high_held = 1'b1;
    end else begin
      step_cps.push_back(21'(u));
    end
  endfunction

  function void note_byte(logic [7:0] b, logic last);
    logic [15:0] u;
    logic [15:0] h;
    due_cp_t     d;
    step_cps.delete();
    if (mode == tcud_pkg::MODE_PLAIN) begin
      step_cps.push_back(21'(b));
    end else if (mode == tcud_pkg::MODE_EXTRA) begin
      if (b >= 8'h80 && b <= 8'h9F)
        step_cps.push_back(21'(extra_cp[b[4:0]]));
      else
        step_cps.push_back(21'(b));
    end else if (!half_full) begin
      if (last) begin
        if (high_held)
          step_cps.push_back(21'(high_word));
        step_cps.push_back(21'd0);
      end else begin
        half_byte = b;
        half_full = 1'b1;
      end
    end else begin
      u = (mode == tcud_pkg::MODE_UTF16LE) ? {b, half_byte} : {half_byte, b};
      half_full = 1'b0;
      half_byte = 8'h00;
      if (high_held) begin
        h = high_word;
        high_held = 1'b0;
        high_word = 16'h0000;
        if (u >= 16'hDC00 && u <= 16'hDFFF) begin
          step_cps.push_back(21'h10000 + 21'({h[9:0], u[9:0]}));
        end else begin
          step_cps.push_back(21'(h));
          take_unit(u, last);
        end
      end else begin
        take_unit(u, last);
      end
    end
    if (last) begin
      if (step_cps.size() == 0)
        step_cps.push_back(21'd0);
      clear_text();
    end
    foreach (step_cps[i]) begin
      d.cp  = step_cps[i];
      d.eot = last && (i == step_cps.size() - 1);
      due.push_back(d);
    end
  endfunction

  task report(string what);
    errors++;
    $display("%0t ns: mismatch: %s", $realtime, what);
  endtask

  task check_cp(logic [20:0] cp, logic eot);
    due_cp_t want;
    if (due.size() == 0) begin
      report($sformatf("code point %h end_of_text %b with nothing due", cp, eot));
      return;
    end
    want = due.pop_front();
    if (cp !== want.cp)
      report($sformatf("code point %h, expected %h", cp, want.cp));
    if (eot !== want.eot)
      report($sformatf("end_of_text %b on code point %h, expected %b", eot, cp, want.eot));
  endtask
endclass

module tb_text_code_unit_decoder;
  import tcud_pkg::*;

  logic clk;
  logic rst;

  tcud_text_if   text_ch ();
  tcud_result_if res_ch ();
  tcud_cfg_if    cfg_ch ();

  text_code_unit_decoder u_top (
    .clk    (clk),
    .rst    (rst),
    .text   (text_ch),
    .result (res_ch),
    .cfg    (cfg_ch)
  );

  code_point_book book;

  // Percent chances that the sender inserts an idle cycle before a beat and that the
  // receiver holds off ready in a given cycle.
  int send_idle_pct;
  int stall_pct;
  int bytes_sent;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop in case a handshake never completes.
  initial begin
    #5_000_000;
    $display("tb_text_code_unit_decoder NOT OK");
    $finish;
  end

  // The receiver decides at each falling edge whether it takes a result beat in the next cycle.
  always @(negedge clk) begin
    res_ch.ready <= ($urandom_range(99) >= stall_pct);
  end

  // Every accepted beat is seen here at the rising edge. Results are checked before the
  // byte of the same edge is noted; a byte's first result never shows at its own edge.
  always @(posedge clk) begin
    if (!rst) begin
      if (res_ch.valid && res_ch.ready)
        book.check_cp(res_ch.code_point, res_ch.end_of_text);
      if (text_ch.valid && text_ch.ready)
        book.note_byte(text_ch.data_byte, text_ch.final_byte);
    end
  end

  // Offers one byte, with random idle cycles first, and returns at the falling edge after
  // it was taken. Valid stays high so that back-to-back beats need no extra cycle.
  task automatic send_byte(logic [7:0] b, logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      text_ch.valid = 1'b0;
      @(negedge clk);
    end
    text_ch.valid      = 1'b1;
    text_ch.data_byte  = b;
    text_ch.final_byte = last;
    do @(posedge clk); while (!text_ch.ready);
    @(negedge clk);
    bytes_sent++;
  endtask

  // Sends a byte sequence; when close is set the last byte ends the text.
  task automatic send_seq(byte_q_t bs, logic close);
    foreach (bs[i])
      send_byte(bs[i], close && (i == bs.size() - 1));
  endtask

  // The sender stops and waits until every due result has come back.
  task automatic wait_drained();
    text_ch.valid = 1'b0;
    while (book.due.size() != 0)
      @(negedge clk);
  endtask

  // The mode is written once every due result has come back. A byte that is merely
  // held in a UTF-16 mode causes no result and is dropped by the mode write.
  task automatic write_mode(text_mode_t m);
    wait_drained();
    repeat (4) @(negedge clk);
    cfg_ch.valid     = 1'b1;
    cfg_ch.text_mode = m;
    do @(posedge clk); while (!cfg_ch.ready);
    book.set_mode(m);
    @(negedge clk);
    cfg_ch.valid = 1'b0;
  endtask

  // A UTF-16 text in the given byte order: plain and random units, byte order
  // marks, surrogate pairs, lone high and lone low surrogates, and now and then an odd
  // trailing byte.
  function automatic byte_q_t utf16_text(logic big);
    byte_q_t     bs;
    logic [15:0] words [$];
    int          units;
    units = $urandom_range(1, 8);
    repeat (units) begin
      case ($urandom_range(9))
        0: words.push_back(16'hFEFF);
        1, 2: begin
          words.push_back(16'hD800 | 16'($urandom_range(16'h03FF)));
          words.push_back(16'hDC00 | 16'($urandom_range(16'h03FF)));
        end
        3: words.push_back(16'hD800 | 16'($urandom_range(16'h03FF)));
        4: words.push_back(16'hDC00 | 16'($urandom_range(16'h03FF)));
        5, 6: words.push_back(16'($urandom_range(16'h007F)));
        default: words.push_back(16'($urandom_range(16'hFFFF)));
      endcase
    end
    foreach (words[i]) begin
      if (big) begin
        bs.push_back(words[i][15:8]);
        bs.push_back(words[i][7:0]);
      end else begin
        bs.push_back(words[i][7:0]);
        bs.push_back(words[i][15:8]);
      end
    end
    if ($urandom_range(5) == 0)
      bs.push_back(8'($urandom_range(255)));
    return bs;
  endfunction

  // Random bytes; with bias set, half of them are drawn from the range of the extra table.
  function automatic byte_q_t byte_text(logic bias);
    byte_q_t bs;
    int      len;
    len = $urandom_range(1, 10);
    repeat (len) begin
      if (bias && $urandom_range(1))
        bs.push_back(8'($urandom_range(8'h9F, 8'h80)));
      else
        bs.push_back(8'($urandom_range(255)));
    end
    return bs;
  endfunction

  initial begin
    text_mode_t mode;
    int         phase_start;
    int         texts;
    byte_q_t    bs;

    book               = new();
    rst                = 1'b1;
    text_ch.valid      = 1'b0;
    text_ch.data_byte  = 8'h00;
    text_ch.final_byte = 1'b0;
    cfg_ch.valid       = 1'b0;
    cfg_ch.text_mode   = MODE_PLAIN;
    send_idle_pct      = 0;
    stall_pct          = 0;
    bytes_sent         = 0;

    repeat (5) @(negedge clk);
    rst = 1'b0;

    // Directed part. Plain mode straight out of reset: both byte extremes.
    send_seq('{8'h00, 8'hFF}, 1'b1);

    // 8-bit mode: just below, at both ends of, and just above the table range.
    write_mode(MODE_EXTRA);
    send_seq('{8'h7F, 8'h80, 8'h9F, 8'hA0}, 1'b1);

    // Little endian: a byte order mark, a surrogate pair, an unpaired high surrogate
    // followed by a letter, and a high surrogate as the final unit.
    write_mode(MODE_UTF16LE);
    send_seq('{8'hFF, 8'hFE, 8'h3D, 8'hD8, 8'h00, 8'hDE}, 1'b0);
    send_seq('{8'h3D, 8'hD8, 8'h41, 8'h00, 8'h00, 8'hD8}, 1'b1);

    // A half unit left held must be dropped by the mode write.
    send_seq('{8'h41}, 1'b0);
    write_mode(MODE_UTF16BE);

    // Big endian: a high surrogate cut off by a byte order mark, then another high
    // surrogate followed by an odd trailing byte.
    send_seq('{8'hD8, 8'h00, 8'hFE, 8'hFF, 8'hD8, 8'h00, 8'h42}, 1'b1);

    // Random part. Each of the four idling styles meets each of the four modes.
    for (int phase = 0; phase < 16; phase++) begin
      mode = text_mode_t'(phase % 4);
      write_mode(mode);
      case (phase / 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 85; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 85; end
        default: begin send_idle_pct = 7; stall_pct = 7; end
      endcase
      phase_start = bytes_sent;
      texts = 0;
      while (bytes_sent - phase_start < 56) begin
        if (mode == MODE_UTF16LE || mode == MODE_UTF16BE) begin
          // Mostly UTF-16 units; now and then plain noise.
          if ($urandom_range(7) == 0)
            bs = byte_text(1'b0);
          else
            bs = utf16_text(mode == MODE_UTF16BE);
        end else begin
          bs = byte_text(mode == MODE_EXTRA);
        end
        // Most texts end with a final byte; some run on into the next one.
        send_seq(bs, $urandom_range(7) != 0);
        // Once per phase the sender holds off until the result side has emptied.
        if (texts == 0)
          wait_drained();
        texts++;
      end
    end

    // Let the remaining results out with the receiver always ready, then keep watching
    // for any result that should not be there.
    stall_pct = 0;
    text_ch.valid = 1'b0;
    for (int i = 0; i < 20000 && book.due.size() != 0; i++)
      @(negedge clk);
    repeat (8) @(negedge clk);
    if (book.due.size() != 0)
      book.report($sformatf("%0d code points never came", book.due.size()));

    if (book.errors == 0) begin
      $display("tb_text_code_unit_decoder OK");
    end else begin
      $display("tb_text_code_unit_decoder NOT OK");
    end
    $finish;
  end

endmodule
